FILE: src/ptl_pkg.sv
// Shared widths, types, register codes and step functions for the point-to-line core.
`timescale 1ns / 1ps

package ptl_pkg;

    // Coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CW          = COORD_WIDTH;

    // Internal widths, all exact
    localparam int V_W    = CW + 1;          // p - o
    localparam int NN_W   = 2 * CW;          // |d|^2
    localparam int DOT_W  = 2 * CW + 2;      // d.v, signed
    localparam int VV_W   = 2 * CW + 2;      // |v|^2
    localparam int DM_W   = 2 * CW + 1;      // |d.v|
    localparam int LO_W   = CW + 1;          // low slice of |d.v|
    localparam int HI_W   = DM_W - LO_W;     // high slice of |d.v|
    localparam int QW     = 2 * CW + 2;      // quotient bits
    localparam int N_W    = QW + NN_W;       // dividend bits
    localparam int SQ_W   = QW / 2;          // root bits
    localparam int RM_W   = SQ_W + 2;        // root remainder bits
    localparam int F_W    = QW + 2;          // foot sum before clamp
    localparam int DIST_W = CW - 1;
    localparam int LANES  = 4;               // three foot lanes and the distance lane
    localparam int CFG_IDX_W = 3;

    localparam logic [CW-1:0] DIR_Z_RESET = CW'(64'd1 << FRAC_BITS);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } reg_idx_t;

    typedef logic [2:0][CW-1:0] vec3_t;

    typedef struct packed {
        vec3_t origin;
        vec3_t dir;
    } line_t;

    typedef logic [LANES-1:0][N_W-1:0]  num_vec_t;
    typedef logic [LANES-1:0][QW-1:0]   quo_vec_t;
    typedef logic [LANES-1:0][NN_W-1:0] rem_vec_t;

    // Sideband that rides along the divider
    typedef struct packed {
        logic [VV_W-1:0] vv;
        logic [2:0]      neg;
    } div_side_t;

    typedef struct packed {
        logic [QW-1:0]   x;
        logic [RM_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sq_state_t;

    typedef struct packed {
        vec3_t             foot;
        logic [DIST_W-1:0] distance;
        logic              degenerate;
    } result_t;

    // One restoring division step: remainder in the top bits, quotient fills the bottom
    function automatic logic [N_W-1:0] div_step(input logic [N_W-1:0] rq,
                                                input logic [NN_W-1:0] nn);
        logic [NN_W:0] t;
        logic [NN_W:0] d;
        t = rq[N_W-1:QW-1];
        d = t - {1'b0, nn};
        if (t >= {1'b0, nn}) begin
            div_step = {d[NN_W-1:0], rq[QW-2:0], 1'b1};
        end else begin
            div_step = {t[NN_W-1:0], rq[QW-2:0], 1'b0};
        end
    endfunction

    // One digit of the restoring integer square root
    function automatic sq_state_t sqrt_step(input sq_state_t s);
        logic [RM_W+1:0] t;
        logic [RM_W+1:0] tr;
        sq_state_t       r;
        t   = {s.rem, s.x[QW-1 -: 2]};
        tr  = {{(RM_W - SQ_W){1'b0}}, s.root, 2'b01};
        r.x = {s.x[QW-3:0], 2'b00};
        if (t >= tr) begin
            r.rem  = RM_W'(t - tr);
            r.root = {s.root[SQ_W-2:0], 1'b1};
        end else begin
            r.rem  = t[RM_W-1:0];
            r.root = {s.root[SQ_W-2:0], 1'b0};
        end
        sqrt_step = r;
    endfunction

endpackage

FILE: src/ptl_front.sv
// Front stages: offset, dot products, magnitudes and wide dividend assembly.
`timescale 1ns / 1ps

module ptl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  ptl_pkg::vec3_t       in_point,
    input  ptl_pkg::line_t       line,
    output logic                 out_valid,
    output ptl_pkg::num_vec_t    out_num,
    output ptl_pkg::div_side_t   out_side
);

    logic [4:0] vld_reg;

    // stage A
    logic signed [ptl_pkg::V_W-1:0] v_reg [3];
    // stage B
    logic signed [ptl_pkg::CW+ptl_pkg::V_W-1:0] dv_full [3];
    logic signed [2*ptl_pkg::V_W-1:0]           vsq_full [3];
    logic signed [ptl_pkg::CW+ptl_pkg::V_W-1:0] dv_reg [3];
    logic [ptl_pkg::VV_W-1:0]                   vsq_reg [3];
    // stage C
    logic signed [ptl_pkg::DOT_W-1:0] dot_sum;
    logic signed [ptl_pkg::DOT_W-1:0] dot_reg;
    logic [ptl_pkg::VV_W-1:0]         vv_c_reg;
    // stage D
    logic [ptl_pkg::DOT_W-1:0]          dmag_full;
    logic [ptl_pkg::LO_W-1:0]           dlo;
    logic [ptl_pkg::HI_W-1:0]           dhi;
    logic [ptl_pkg::CW-1:0]             dabs [3];
    logic [ptl_pkg::CW+ptl_pkg::LO_W-1:0] dl_full [3];
    logic [ptl_pkg::CW+ptl_pkg::HI_W-1:0] dh_full [3];
    logic [2*ptl_pkg::HI_W-1:0]           hh_full;
    logic [ptl_pkg::HI_W+ptl_pkg::LO_W-1:0] hl_full;
    logic [2*ptl_pkg::LO_W-1:0]           ll_full;
    logic [ptl_pkg::CW+ptl_pkg::LO_W-1:0] dl_reg [3];
    logic [ptl_pkg::CW+ptl_pkg::HI_W-1:0] dh_reg [3];
    logic [2*ptl_pkg::HI_W-1:0]           hh_reg;
    logic [ptl_pkg::HI_W+ptl_pkg::LO_W-1:0] hl_reg;
    logic [2*ptl_pkg::LO_W-1:0]           ll_reg;
    logic [2:0]                           neg_d_reg;
    logic [ptl_pkg::VV_W-1:0]             vv_d_reg;
    // stage E
    ptl_pkg::num_vec_t  num_reg;
    ptl_pkg::div_side_t side_reg;

    // valid bits move with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // products and magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_full[i]  = $signed(line.dir[i]) * v_reg[i];
            vsq_full[i] = v_reg[i] * v_reg[i];
        end
        dot_sum = {{(ptl_pkg::DOT_W-ptl_pkg::CW-ptl_pkg::V_W){dv_reg[0][ptl_pkg::CW+ptl_pkg::V_W-1]}},
                   dv_reg[0]}
                + {{(ptl_pkg::DOT_W-ptl_pkg::CW-ptl_pkg::V_W){dv_reg[1][ptl_pkg::CW+ptl_pkg::V_W-1]}},
                   dv_reg[1]}
                + {{(ptl_pkg::DOT_W-ptl_pkg::CW-ptl_pkg::V_W){dv_reg[2][ptl_pkg::CW+ptl_pkg::V_W-1]}},
                   dv_reg[2]};
        dmag_full = dot_reg[ptl_pkg::DOT_W-1] ? (ptl_pkg::DOT_W'(0) - dot_reg) : dot_reg;
        dlo = dmag_full[ptl_pkg::LO_W-1:0];
        dhi = dmag_full[ptl_pkg::DM_W-1:ptl_pkg::LO_W];
        for (int i = 0; i < 3; i++) begin
            dabs[i]    = line.dir[i][ptl_pkg::CW-1] ? (ptl_pkg::CW'(0) - line.dir[i]) : line.dir[i];
            dl_full[i] = dabs[i] * dlo;
            dh_full[i] = dabs[i] * dhi;
        end
        hh_full = dhi * dhi;
        hl_full = dhi * dlo;
        ll_full = dlo * dlo;
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                v_reg[i]   <= {in_point[i][ptl_pkg::CW-1], in_point[i]}
                            - {line.origin[i][ptl_pkg::CW-1], line.origin[i]};
                dv_reg[i]  <= dv_full[i];
                vsq_reg[i] <= vsq_full[i];
                dl_reg[i]  <= dl_full[i];
                dh_reg[i]  <= dh_full[i];
                neg_d_reg[i] <= dot_reg[ptl_pkg::DOT_W-1] ^ line.dir[i][ptl_pkg::CW-1];
                num_reg[i] <= {{(ptl_pkg::N_W-ptl_pkg::CW-ptl_pkg::HI_W-ptl_pkg::LO_W){1'b0}},
                               dh_reg[i], {ptl_pkg::LO_W{1'b0}}}
                            + {{(ptl_pkg::N_W-ptl_pkg::CW-ptl_pkg::LO_W){1'b0}}, dl_reg[i]};
            end
            dot_reg  <= dot_sum;
            vv_c_reg <= vsq_reg[0] + vsq_reg[1] + vsq_reg[2];
            hh_reg   <= hh_full;
            hl_reg   <= hl_full;
            ll_reg   <= ll_full;
            vv_d_reg <= vv_c_reg;
            num_reg[ptl_pkg::LANES-1] <= {hh_reg, {(2*ptl_pkg::LO_W){1'b0}}}
                + {{(ptl_pkg::N_W-ptl_pkg::HI_W-2*ptl_pkg::LO_W-1){1'b0}},
                   hl_reg, {(ptl_pkg::LO_W+1){1'b0}}}
                + {{(ptl_pkg::N_W-2*ptl_pkg::LO_W){1'b0}}, ll_reg};
            side_reg.vv  <= vv_d_reg;
            side_reg.neg <= neg_d_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_num   = num_reg;
    assign out_side  = side_reg;

endmodule

FILE: src/ptl_div.sv
// Four-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
`timescale 1ns / 1ps

module ptl_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ce,
    input  logic                      in_valid,
    input  ptl_pkg::num_vec_t         in_num,
    input  ptl_pkg::div_side_t        in_side,
    input  logic [ptl_pkg::NN_W-1:0]  nn,
    output logic                      out_valid,
    output ptl_pkg::quo_vec_t         out_quo,
    output ptl_pkg::rem_vec_t         out_rem,
    output ptl_pkg::div_side_t        out_side
);

    logic               vld_reg  [ptl_pkg::QW];
    ptl_pkg::num_vec_t  rq_reg   [ptl_pkg::QW];
    ptl_pkg::div_side_t side_reg [ptl_pkg::QW];

    // one stage per quotient bit
    for (genvar s = 0; s < ptl_pkg::QW; s++) begin : g_stage
        logic               prev_vld;
        ptl_pkg::num_vec_t  prev_num;
        ptl_pkg::div_side_t prev_side;

        if (s == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_num  = in_num;
            assign prev_side = in_side;
        end else begin : g_next
            assign prev_vld  = vld_reg[s-1];
            assign prev_num  = rq_reg[s-1];
            assign prev_side = side_reg[s-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (ce) begin
                vld_reg[s] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                for (int l = 0; l < ptl_pkg::LANES; l++) begin
                    rq_reg[s][l] <= ptl_pkg::div_step(prev_num[l], nn);
                end
                side_reg[s] <= prev_side;
            end
        end
    end

    // split remainder and quotient
    always_comb begin
        for (int l = 0; l < ptl_pkg::LANES; l++) begin
            out_quo[l] = rq_reg[ptl_pkg::QW-1][l][ptl_pkg::QW-1:0];
            out_rem[l] = rq_reg[ptl_pkg::QW-1][l][ptl_pkg::N_W-1:ptl_pkg::QW];
        end
    end

    assign out_valid = vld_reg[ptl_pkg::QW-1];
    assign out_side  = side_reg[ptl_pkg::QW-1];

    // distance-lane remainder must end below a nonzero divisor
    a_rem_below_nn: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (nn != '0) |-> (out_rem[ptl_pkg::LANES-1] < nn))
        else $error("divider remainder not below divisor");

endmodule

FILE: src/ptl_sqrt.sv
// Pipelined integer square root, one root bit per stage, foot carried alongside.
`timescale 1ns / 1ps

module ptl_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ce,
    input  logic                      in_valid,
    input  logic [ptl_pkg::QW-1:0]    in_rad,
    input  ptl_pkg::vec3_t            in_foot,
    output logic                      out_valid,
    output logic [ptl_pkg::SQ_W-1:0]  out_root,
    output ptl_pkg::vec3_t            out_foot
);

    logic               vld_reg  [ptl_pkg::SQ_W];
    ptl_pkg::sq_state_t st_reg   [ptl_pkg::SQ_W];
    ptl_pkg::vec3_t     foot_reg [ptl_pkg::SQ_W];

    for (genvar s = 0; s < ptl_pkg::SQ_W; s++) begin : g_stage
        logic               prev_vld;
        ptl_pkg::sq_state_t prev_st;
        ptl_pkg::vec3_t     prev_foot;

        if (s == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_st   = {in_rad, {ptl_pkg::RM_W{1'b0}}, {ptl_pkg::SQ_W{1'b0}}};
            assign prev_foot = in_foot;
        end else begin : g_next
            assign prev_vld  = vld_reg[s-1];
            assign prev_st   = st_reg[s-1];
            assign prev_foot = foot_reg[s-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (ce) begin
                vld_reg[s] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                st_reg[s]   <= ptl_pkg::sqrt_step(prev_st);
                foot_reg[s] <= prev_foot;
            end
        end
    end

    assign out_valid = vld_reg[ptl_pkg::SQ_W-1];
    assign out_root  = st_reg[ptl_pkg::SQ_W-1].root;
    assign out_foot  = foot_reg[ptl_pkg::SQ_W-1];

endmodule

FILE: src/ptl_skid.sv
// Output register with a one-entry skid buffer that absorbs the pipeline stall latency.
`timescale 1ns / 1ps

module ptl_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ptl_pkg::result_t  in_data,
    input  logic              m_ready,
    output logic              m_valid,
    output ptl_pkg::result_t  m_data,
    output logic              full
);

    logic             out_vld_reg;
    logic             skid_vld_reg;
    ptl_pkg::result_t out_data_reg;
    ptl_pkg::result_t skid_data_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg  <= skid_vld_reg | push;
            skid_vld_reg <= 1'b0;
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : in_data;
        end else if (push) begin
            skid_data_reg <= in_data;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;
    assign full    = skid_vld_reg;

    // skid only fills behind a held output
    a_full_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> m_valid)
        else $error("skid entry held without output transaction pending");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !m_ready |=> full)
        else $error("skid entry lost while output stalled");

endmodule

FILE: src/point_to_line_distance_core.sv
// Top level: perpendicular foot and distance from a 3D point to a configured line.
//
// Usage:
//   Input channel s_valid/s_ready carries one point (s_point_x/y/z, signed Q16.16).
//   Result channel m_valid/m_ready carries the foot (m_foot_x/y/z, saturated),
//   the distance (m_distance, unsigned, saturated) and m_degenerate.
//   Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; index 0..2 is
//   the line origin, 3..5 the direction, other indexes are ignored. cfg_ready is
//   always high. Write configuration only while no transaction is in flight.
//   Throughput: one point per cycle while s_ready is high. A point passes the
//   front stages, the divider (one quotient bit per stage, 2*COORD_WIDTH+2
//   stages), a foot register, the square root (one root bit per stage,
//   COORD_WIDTH+1 stages) and the output register on its way to m_valid.
//   Reset (aresetn low, synchronous) empties the pipeline and loads origin (0,0,0)
//   and direction (0,0,1.0).
//   When m_ready is low the result holds; one more result is caught in a skid
//   entry, then the whole pipeline freezes and s_ready drops until it drains.
`timescale 1ns / 1ps

module point_to_line_distance_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ptl_pkg::CW-1:0]            s_point_x,
    input  logic [ptl_pkg::CW-1:0]            s_point_y,
    input  logic [ptl_pkg::CW-1:0]            s_point_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ptl_pkg::CW-1:0]            m_foot_x,
    output logic [ptl_pkg::CW-1:0]            m_foot_y,
    output logic [ptl_pkg::CW-1:0]            m_foot_z,
    output logic [ptl_pkg::DIST_W-1:0]        m_distance,
    output logic                              m_degenerate,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptl_pkg::CW-1:0]            cfg_data
);

    ptl_pkg::line_t line_reg;
    logic signed [ptl_pkg::NN_W-1:0] dsq_full [3];
    logic [ptl_pkg::NN_W-1:0]        dsq_reg  [3];
    logic [ptl_pkg::NN_W-1:0]        nn_reg;
    logic                            nn_zero;

    logic               ce;
    logic               skid_full;
    ptl_pkg::vec3_t     in_point;

    logic               fr_valid;
    ptl_pkg::num_vec_t  fr_num;
    ptl_pkg::div_side_t fr_side;

    logic               div_valid;
    ptl_pkg::quo_vec_t  div_quo;
    ptl_pkg::rem_vec_t  div_rem;
    ptl_pkg::div_side_t div_side;

    logic [ptl_pkg::QW:0]     f_qr  [3];
    logic [ptl_pkg::F_W-1:0]  f_sum [3];
    ptl_pkg::vec3_t           f_foot;
    logic [ptl_pkg::QW-1:0]   f_d2;
    logic                     f_vld_reg;
    ptl_pkg::vec3_t           f_foot_reg;
    logic [ptl_pkg::QW-1:0]   f_d2_reg;

    logic                      sq_valid;
    logic [ptl_pkg::SQ_W-1:0]  sq_root;
    ptl_pkg::vec3_t            sq_foot;
    ptl_pkg::result_t          res;
    ptl_pkg::result_t          m_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg.origin <= '0;
            line_reg.dir    <= {ptl_pkg::DIR_Z_RESET, {(2*ptl_pkg::CW){1'b0}}};
        end else if (cfg_valid) begin
            case (cfg_index)
                ptl_pkg::REG_ORIGIN_X: line_reg.origin[0] <= cfg_data;
                ptl_pkg::REG_ORIGIN_Y: line_reg.origin[1] <= cfg_data;
                ptl_pkg::REG_ORIGIN_Z: line_reg.origin[2] <= cfg_data;
                ptl_pkg::REG_DIR_X:    line_reg.dir[0]    <= cfg_data;
                ptl_pkg::REG_DIR_Y:    line_reg.dir[1]    <= cfg_data;
                ptl_pkg::REG_DIR_Z:    line_reg.dir[2]    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // |d|^2 follows the direction registers through dsq_reg and then nn_reg
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dsq_full[i] = $signed(line_reg.dir[i]) * $signed(line_reg.dir[i]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            dsq_reg[i] <= dsq_full[i];
        end
        nn_reg <= dsq_reg[0] + dsq_reg[1] + dsq_reg[2];
    end

    assign nn_zero = (nn_reg == '0);

    // pipeline advances unless the skid entry is occupied
    assign ce       = !skid_full;
    assign s_ready  = ce;
    assign in_point = {s_point_z, s_point_y, s_point_x};

    ptl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_point  (in_point),
        .line      (line_reg),
        .out_valid (fr_valid),
        .out_num   (fr_num),
        .out_side  (fr_side)
    );

    ptl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_side   (fr_side),
        .nn        (nn_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_rem   (div_rem),
        .out_side  (div_side)
    );

    // rounding, sign, origin offset and clamp; squared distance
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_qr[i]  = {1'b0, div_quo[i]}
                     + {{ptl_pkg::QW{1'b0}}, ({div_rem[i], 1'b0} >= {1'b0, nn_reg})};
            f_sum[i] = {{(ptl_pkg::F_W-ptl_pkg::CW){line_reg.origin[i][ptl_pkg::CW-1]}},
                        line_reg.origin[i]}
                     + (div_side.neg[i] ? (ptl_pkg::F_W'(0) - {1'b0, f_qr[i]})
                                        : {1'b0, f_qr[i]});
            if ((f_sum[i][ptl_pkg::F_W-1:ptl_pkg::CW-1] == '0) ||
                (f_sum[i][ptl_pkg::F_W-1:ptl_pkg::CW-1] == '1)) begin
                f_foot[i] = f_sum[i][ptl_pkg::CW-1:0];
            end else if (f_sum[i][ptl_pkg::F_W-1]) begin
                f_foot[i] = {1'b1, {(ptl_pkg::CW-1){1'b0}}};
            end else begin
                f_foot[i] = {1'b0, {(ptl_pkg::CW-1){1'b1}}};
            end
        end
        // floor(vv - dot^2/nn) = vv - ceil(dot^2/nn)
        f_d2 = div_side.vv - div_quo[ptl_pkg::LANES-1]
             - {{(ptl_pkg::QW-1){1'b0}}, (div_rem[ptl_pkg::LANES-1] != '0)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (ce) begin
            f_vld_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_foot_reg <= f_foot;
            f_d2_reg   <= f_d2;
        end
    end

    ptl_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_vld_reg),
        .in_rad    (f_d2_reg),
        .in_foot   (f_foot_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_foot  (sq_foot)
    );

    // saturate distance, substitute origin for a zero direction
    always_comb begin
        if (nn_zero) begin
            res.foot       = line_reg.origin;
            res.distance   = '0;
            res.degenerate = 1'b1;
        end else begin
            res.foot       = sq_foot;
            res.distance   = (sq_root[ptl_pkg::SQ_W-1:ptl_pkg::DIST_W] != '0)
                           ? {ptl_pkg::DIST_W{1'b1}} : sq_root[ptl_pkg::DIST_W-1:0];
            res.degenerate = 1'b0;
        end
    end

    ptl_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (sq_valid && ce),
        .in_data  (res),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data),
        .full     (skid_full)
    );

    assign m_foot_x     = m_data.foot[0];
    assign m_foot_y     = m_data.foot[1];
    assign m_foot_z     = m_data.foot[2];
    assign m_distance   = m_data.distance;
    assign m_degenerate = m_data.degenerate;

    // degenerate results carry the origin and zero distance
    a_degen_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> (m_distance == '0))
        else $error("degenerate result with nonzero distance");

    a_degen_foot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> (m_foot_x == line_reg.origin[0]) &&
                                    (m_foot_y == line_reg.origin[1]) &&
                                    (m_foot_z == line_reg.origin[2]))
        else $error("degenerate result foot differs from origin");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the point-to-line foot and distance core.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY       = 3 * ptl_pkg::CW + 10;
    localparam int N_PHASES      = 19;
    localparam int N_PHASE_ITEMS = 95;
    localparam int N_BURST       = 160;
    localparam int BURST_PHASE   = 4;
    localparam longint LIMIT     = 2000000;

    typedef struct packed {
        logic [ptl_pkg::CW-1:0]     fx;
        logic [ptl_pkg::CW-1:0]     fy;
        logic [ptl_pkg::CW-1:0]     fz;
        logic [ptl_pkg::DIST_W-1:0] dist_val;
        logic                       degen;
    } foot_res_t;

    typedef struct {
        logic [ptl_pkg::CW-1:0] px, py, pz;
        logic                   known;      // expected result typed in
        foot_res_t              res;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ptl_pkg::CW-1:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ptl_pkg::CW-1:0] m_foot_x, m_foot_y, m_foot_z;
    logic [ptl_pkg::DIST_W-1:0] m_distance;
    logic m_degenerate;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ptl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ptl_pkg::CW-1:0] cfg_data = '0;

    point_to_line_distance_core u_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor's copy of the line registers
    logic signed [ptl_pkg::CW-1:0] line_org [3];
    logic signed [ptl_pkg::CW-1:0] line_dvec [3];

    foot_res_t pending_feet[$];
    int  n_fail = 0;
    int  n_checked = 0;
    int  n_degen = 0;
    int  n_sat = 0;
    longint cyc = 0;
    bit  hold_sink = 1'b0;
    bit  hold_req = 1'b0;

    function automatic logic [127:0] isqrt(logic [127:0] val);
        logic [127:0] s, c;
        s = 0;
        for (int k = 63; k >= 0; k--) begin
            c = s | (128'd1 << k);
            if (c * c <= val) s = c;
        end
        return s;
    endfunction

    // Foot and distance of one point against the current line
    function automatic foot_res_t project_point(logic [ptl_pkg::CW-1:0] px,
                                                logic [ptl_pkg::CW-1:0] py,
                                                logic [ptl_pkg::CW-1:0] pz);
        logic signed [255:0] v[3], d[3], nn, dot, vv, num, q, rem, sum, d2;
        logic signed [255:0] cmax, cmin;
        logic [ptl_pkg::CW-1:0] p[3];
        foot_res_t r;
        p[0] = px; p[1] = py; p[2] = pz;
        cmax = (256'sd1 <<< (ptl_pkg::CW - 1)) - 1;
        cmin = -cmax - 1;
        nn = 0; dot = 0; vv = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = 256'(signed'(p[i])) - 256'(line_org[i]);
            d[i] = 256'(line_dvec[i]);
            nn  += d[i] * d[i];
            dot += d[i] * v[i];
            vv  += v[i] * v[i];
        end
        if (nn == 0) begin
            r.fx = line_org[0]; r.fy = line_org[1]; r.fz = line_org[2];
            r.dist_val = '0; r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            num = d[i] * dot;
            q   = (num < 0 ? -num : num) / nn;
            rem = (num < 0 ? -num : num) % nn;
            if (2 * rem >= nn) q += 1;
            if (num < 0) q = -q;
            sum = 256'(line_org[i]) + q;
            if (sum > cmax) sum = cmax;
            if (sum < cmin) sum = cmin;
            if (i == 0) r.fx = sum[ptl_pkg::CW-1:0];
            else if (i == 1) r.fy = sum[ptl_pkg::CW-1:0];
            else r.fz = sum[ptl_pkg::CW-1:0];
        end
        num = vv * nn - dot * dot;
        if (num < 0) num = 0;
        d2 = num / nn;
        d2 = 256'(isqrt(d2[127:0]));
        if (d2 > cmax) d2 = cmax;
        r.dist_val = d2[ptl_pkg::DIST_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic write_reg(ptl_pkg::reg_idx_t idx, logic [ptl_pkg::CW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= ptl_pkg::REG_ORIGIN_Z) line_org[idx] = val;
        else line_dvec[idx - ptl_pkg::REG_DIR_X] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_line(logic [ptl_pkg::CW-1:0] ox, oy, oz, dx, dy, dz);
        write_reg(ptl_pkg::REG_ORIGIN_X, ox); write_reg(ptl_pkg::REG_ORIGIN_Y, oy);
        write_reg(ptl_pkg::REG_ORIGIN_Z, oz); write_reg(ptl_pkg::REG_DIR_X, dx);
        write_reg(ptl_pkg::REG_DIR_Y, dy);    write_reg(ptl_pkg::REG_DIR_Z, dz);
    endtask

    // Send one point; the expected result is queued at acceptance
    task automatic send_point(logic [ptl_pkg::CW-1:0] px, py, pz, bit idle_ok);
        foot_res_t r;
        int n_idle;
        n_idle = idle_ok ? $urandom_range(0, 5) : 0;
        if (n_idle > 0) begin
            s_valid <= 1'b0;
            repeat (n_idle) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_point_x <= px; s_point_y <= py; s_point_z <= pz;
        do @(posedge aclk); while (!s_ready);
        r = project_point(px, py, pz);
        pending_feet = {pending_feet, r};
        @(negedge aclk);
    endtask

    // Stop offering and wait for every expected result
    task automatic drain_all();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_feet.size() != 0);
    endtask

    function automatic logic [ptl_pkg::CW-1:0] rand_coord(int shape);
        case (shape)
            0: return $urandom();
            1: return ptl_pkg::CW'($signed($urandom_range(0, 32'h0FFFFF)) - 32'sh80000);
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 15)
                                           : 32'h80000000 + $urandom_range(0, 15);
            default: return ptl_pkg::CW'($signed($urandom_range(0, 32'h3FFFFFF))
                                         - 32'sh2000000);
        endcase
    endfunction

    // Result checker; randomly holds m_ready low before taking each result
    initial begin
        foot_res_t e;
        int n_wait;
        @(posedge aresetn);
        forever begin
            n_wait = $urandom_range(0, 5);
            repeat (n_wait) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            do begin
                @(negedge aclk);
                m_ready <= !hold_sink;
                @(posedge aclk);
            end while (!(m_valid && m_ready));
            if (pending_feet.size() == 0) begin
                $error("result with no expectation waiting");
                n_fail++;
            end else begin
                e = pending_feet.pop_front();
                n_checked++;
                if (m_foot_x !== e.fx) begin
                    $error("foot_x exp %h got %h", e.fx, m_foot_x); n_fail++;
                end
                if (m_foot_y !== e.fy) begin
                    $error("foot_y exp %h got %h", e.fy, m_foot_y); n_fail++;
                end
                if (m_foot_z !== e.fz) begin
                    $error("foot_z exp %h got %h", e.fz, m_foot_z); n_fail++;
                end
                if (m_distance !== e.dist_val) begin
                    $error("distance exp %h got %h", e.dist_val, m_distance); n_fail++;
                end
                if (m_degenerate !== e.degen) begin
                    $error("degenerate exp %b got %b", e.degen, m_degenerate); n_fail++;
                end
                if (e.degen) n_degen++;
                if (e.dist_val == {ptl_pkg::DIST_W{1'b1}}) n_sat++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("point_to_line_distance_core regression: fail");
            $finish;
        end
    end

    // Long receiver hold-off while a burst of points keeps coming
    initial begin
        wait (hold_req);
        hold_sink = 1'b1;
        repeat (400) @(posedge aclk);
        hold_sink = 1'b0;
    end

    dir_row_t dir_tab[$];

    initial begin
        dir_row_t row;
        foot_res_t kn;
        line_org[0] = '0; line_org[1] = '0; line_org[2] = '0;
        line_dvec[0] = '0; line_dvec[1] = '0; line_dvec[2] = ptl_pkg::DIR_Z_RESET;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows under the reset line (z axis): foot is (0,0,z)
        row.known = 1'b1;
        row.px = 32'h0003_0000; row.py = 32'h0004_0000; row.pz = 32'h0002_0000;
        row.res = '{32'h0, 32'h0, 32'h0002_0000, 31'h0005_0000, 1'b0};
        dir_tab = {dir_tab, row};
        row.px = 32'h0; row.py = 32'h0; row.pz = 32'h7FFF_FFFF;
        row.res = '{32'h0, 32'h0, 32'h7FFF_FFFF, 31'h0, 1'b0};
        dir_tab = {dir_tab, row};
        row.px = 32'h0; row.py = 32'h0; row.pz = 32'h8000_0000;
        row.res = '{32'h0, 32'h0, 32'h8000_0000, 31'h0, 1'b0};
        dir_tab = {dir_tab, row};
        row.known = 1'b0;
        row.px = 32'h8000_0000; row.py = 32'h8000_0000; row.pz = 32'h8000_0000;
        dir_tab = {dir_tab, row};
        row.px = 32'h7FFF_FFFF; row.py = 32'h7FFF_FFFF; row.pz = 32'hFFFF_FFFF;
        dir_tab = {dir_tab, row};
        row.px = 32'h8000_0000; row.py = 32'h7FFF_FFFF; row.pz = 32'h0000_0001;
        dir_tab = {dir_tab, row};
        foreach (dir_tab[i]) begin
            if (dir_tab[i].known) begin
                kn = project_point(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz);
                if (kn != dir_tab[i].res) begin
                    $error("stimulus table row %0d disagrees with predictor", i); n_fail++;
                end
            end
            send_point(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz, 1'b0);
        end
        drain_all();
        repeat (LATENCY) @(negedge aclk);

        // Zero direction: degenerate, foot equals origin
        set_line(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 0, 0, 0);
        send_point(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0);
        drain_all();
        // Extreme origin and direction: foot saturation and huge distance
        set_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        drain_all();
        set_line(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0);
        drain_all();

        // Random phases: new line for each phase; one phase is a stalled burst
        for (int ph = 0; ph < N_PHASES; ph++) begin
            int ls;
            int n_items;
            ls = $urandom_range(0, 3);
            set_line(rand_coord(ls), rand_coord(ls), rand_coord(ls),
                     ($urandom_range(0, 5) == 0) ? '0 : rand_coord($urandom_range(0, 3)),
                     rand_coord($urandom_range(0, 3)),
                     (ph == 7) ? '0 : rand_coord($urandom_range(0, 3)));
            if (ph == 9) set_line(line_org[0], line_org[1], line_org[2], 0, 0, 0);
            n_items = (ph == BURST_PHASE) ? N_BURST : N_PHASE_ITEMS;
            if (ph == BURST_PHASE) hold_req = 1'b1;
            for (int k = 0; k < n_items; k++)
                send_point(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                           rand_coord($urandom_range(0, 3)),
                           (ph != BURST_PHASE) && ($urandom_range(0, 4) != 0));
            drain_all();
        end

        repeat (LATENCY + 20) @(negedge aclk);
        $display("Checked %0d results over 20+ line settings (%0d degenerate, %0d at max distance).",
                 n_checked, n_degen, n_sat);
        if (n_fail == 0 && pending_feet.size() == 0)
            $display("point_to_line_distance_core regression: pass");
        else
            $display("point_to_line_distance_core regression: fail");
        $finish;
    end

endmodule
